// ===== rtl/combined_frame_splitter_defines.svh =====
// Assertion macros shared by the combined frame splitter RTL.
// No dependencies; included by files that carry assertions.
`ifndef COMBINED_FRAME_SPLITTER_DEFINES_SVH
`define COMBINED_FRAME_SPLITTER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define CFS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define CFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CFS_ASSERT_NOW(lbl, ante, cons, msg)
`define CFS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/cfs_pkg.sv =====
// Shared types and constants for the combined frame splitter.
// No dependencies; used by all cfs modules and the top level.
package cfs_pkg;

  localparam int LENGTH_BITS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam logic [7:0] COMBINE_ID_RST = 8'hFF;
  localparam int SUB_SIZE_BITS = 12;
  localparam logic [3:0] SUB_PROT_MASK = 4'hF;

  typedef struct packed {
    logic [7:0] data;
    logic [7:0] protocol;
    logic       first;
    logic       last;
    logic       empty;
  } cfs_item_t;

  typedef struct packed {
    logic      valid;
    cfs_item_t item;
  } cfs_push_t;

endpackage

// ===== rtl/cfs_front.sv =====
// Packet parser: accepts received words, tracks packet and sub-message framing,
// and pushes result items into the queue. Depends on cfs_pkg.
module cfs_front #(
  parameter int LENGTH_BITS = cfs_pkg::LENGTH_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          in_byte,
  input  logic                in_first,
  input  logic [15:0]         pkt_len,
  input  logic [7:0]          pkt_prot,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_data,
  output cfs_pkg::cfs_push_t  push
);

  typedef enum logic [2:0] {
    M_IDLE, M_PASS, M_HDR_LO, M_HDR_HI, M_PAY_FIRST, M_PAY, M_DISCARD
  } mode_t;

  localparam int LB = LENGTH_BITS;
  localparam int SB = cfs_pkg::SUB_SIZE_BITS;
  localparam logic [32:0] LEN_MAX = (33'd1 << LB) - 33'd1;
  localparam logic [LB-1:0] LEN_ONE = LB'(1);
  localparam logic [LB-1:0] LEN_TWO = LB'(2);
  localparam logic [SB-1:0] SUB_ONE = SB'(1);

  mode_t          mode_r, mode_nxt;
  logic [LB-1:0]  br_r, br_nxt;
  logic [7:0]     hlb_r, hlb_nxt;
  logic [SB-1:0]  sbl_r, sbl_nxt;
  logic [7:0]     cp_r, cp_nxt;
  logic [7:0]     cid_r;

  logic [LB-1:0]  len_sat;
  logic [LB-1:0]  r_cur;
  logic [LB-1:0]  r_dec;
  logic [LB-1:0]  after;
  logic [SB-1:0]  size;
  logic [SB-1:0]  sbl_dec;
  mode_t          m_cur;
  logic           done;
  logic           dec;

  always_comb begin
    if ({17'd0, pkt_len} > LEN_MAX) begin
      len_sat = '1;
    end else begin
      len_sat = LB'(pkt_len);
    end
  end

  assign size    = {in_byte, hlb_r[7:4]};
  assign sbl_dec = sbl_r - SUB_ONE;

  always_comb begin
    mode_nxt = mode_r;
    br_nxt   = br_r;
    hlb_nxt  = hlb_r;
    sbl_nxt  = sbl_r;
    cp_nxt   = cp_r;
    push     = '0;
    m_cur    = mode_r;
    r_cur    = br_r;
    done     = 1'b0;
    dec      = 1'b1;
    after    = '0;
    r_dec    = '0;
    if (accept) begin
      if (in_first) begin
        sbl_nxt = '0;
        hlb_nxt = '0;
        if (len_sat == '0) begin
          mode_nxt = M_IDLE;
          br_nxt   = '0;
          done     = 1'b1;
        end else begin
          br_nxt = len_sat;
          cp_nxt = pkt_prot;
          r_cur  = len_sat;
          if (pkt_prot != cid_r) begin
            push.valid         = 1'b1;
            push.item.data     = in_byte;
            push.item.protocol = pkt_prot;
            push.item.first    = 1'b1;
            push.item.last     = (len_sat == LEN_ONE);
            push.item.empty    = 1'b0;
            br_nxt   = len_sat - LEN_ONE;
            mode_nxt = (len_sat == LEN_ONE) ? M_IDLE : M_PASS;
            done     = 1'b1;
          end else begin
            m_cur    = M_HDR_LO;
            mode_nxt = M_HDR_LO;
          end
        end
      end
      if (!done) begin
        after = r_cur - LEN_ONE;
        case (m_cur)
          M_PASS: begin
            push.valid         = 1'b1;
            push.item.data     = in_byte;
            push.item.protocol = cp_r;
            push.item.last     = (r_cur == LEN_ONE);
          end
          M_HDR_LO: begin
            if (r_cur < LEN_TWO) begin
              mode_nxt = M_DISCARD;
            end else begin
              hlb_nxt  = in_byte;
              mode_nxt = M_HDR_HI;
            end
          end
          M_HDR_HI: begin
            cp_nxt = {4'd0, hlb_r[3:0] & cfs_pkg::SUB_PROT_MASK};
            if (after < {{(LB-SB){1'b0}}, size}) begin
              mode_nxt = M_DISCARD;
            end else if (size == '0) begin
              push.valid         = 1'b1;
              push.item.protocol = {4'd0, hlb_r[3:0] & cfs_pkg::SUB_PROT_MASK};
              push.item.first    = 1'b1;
              push.item.last     = 1'b1;
              push.item.empty    = 1'b1;
              mode_nxt = M_HDR_LO;
            end else begin
              sbl_nxt  = size;
              mode_nxt = M_PAY_FIRST;
            end
          end
          M_PAY_FIRST, M_PAY: begin
            push.valid         = 1'b1;
            push.item.data     = in_byte;
            push.item.protocol = cp_r;
            push.item.first    = (m_cur == M_PAY_FIRST);
            push.item.last     = (sbl_r == SUB_ONE);
            sbl_nxt  = sbl_dec;
            mode_nxt = (sbl_dec == '0) ? M_HDR_LO : M_PAY;
          end
          M_DISCARD: begin
          end
          default: begin
            mode_nxt = M_IDLE;
            dec      = 1'b0;
          end
        endcase
        if (dec) begin
          r_dec  = (r_cur != '0) ? (r_cur - LEN_ONE) : r_cur;
          br_nxt = r_dec;
          if (r_dec == '0) begin
            mode_nxt = M_IDLE;
            sbl_nxt  = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      br_r   <= '0;
      hlb_r  <= '0;
      sbl_r  <= '0;
      cp_r   <= '0;
      cid_r  <= cfs_pkg::COMBINE_ID_RST;
    end else begin
      mode_r <= mode_nxt;
      br_r   <= br_nxt;
      hlb_r  <= hlb_nxt;
      sbl_r  <= sbl_nxt;
      cp_r   <= cp_nxt;
      if (cfg_we) begin
        cid_r <= cfg_data;
      end
    end
  end

endmodule

// ===== rtl/cfs_queue.sv =====
// Short result queue between parser and output stage.
// Depends on cfs_pkg and combined_frame_splitter_defines.svh.
`include "combined_frame_splitter_defines.svh"

module cfs_queue #(
  parameter int DEPTH = cfs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cfs_pkg::cfs_push_t push,
  input  logic               pop,
  output logic               full,
  output logic               head_valid,
  output cfs_pkg::cfs_item_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [PW-1:0] PTR_ONE  = PW'(1);
  localparam logic [CW-1:0] CNT_ONE  = CW'(1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  cfs_pkg::cfs_item_t mem [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full       = (cnt_r == CNT_FULL);
  assign head_valid = (cnt_r != '0);
  assign head       = mem[rp_r];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp_r] <= push.item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == PTR_LAST) ? '0 : (wp_r + PTR_ONE);
      end
      if (do_pop) begin
        rp_r <= (rp_r == PTR_LAST) ? '0 : (rp_r + PTR_ONE);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_ONE;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_ONE;
      end
    end
  end

  `CFS_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CNT_FULL, "queue count over depth")
  `CFS_ASSERT_NOW(a_no_lost_push, push.valid, !full, "result pushed into full queue")
  `CFS_ASSERT_NEXT(a_cnt_inc, do_push && !do_pop, cnt_r == $past(cnt_r) + CNT_ONE, "count did not grow")

endmodule

// ===== rtl/cfs_out_stage.sv =====
// Output register stage: takes queue head and presents it on the result channel.
// Depends on cfs_pkg.
module cfs_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  cfs_pkg::cfs_item_t head,
  output logic               pop,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [15:0]        out_tdata,
  output logic               out_tlast,
  output logic [1:0]         out_tuser
);

  logic               valid_r;
  cfs_pkg::cfs_item_t item_r;

  assign pop = head_valid && (!valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!valid_r || out_tready) begin
      valid_r <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      item_r <= head;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {item_r.protocol, item_r.data};
  assign out_tlast  = item_r.last;
  assign out_tuser  = {item_r.empty, item_r.first};

endmodule

// ===== rtl/combined_frame_splitter.sv =====
// Top level of the combined frame splitter: parser, result queue, output stage.
// Depends on cfs_pkg, cfs_front, cfs_queue and cfs_out_stage.
//
// Usage: received packets enter one byte per word on the in_ channel; the word
// flagged by in_tuser carries packet length and protocol. Packets whose protocol
// differs from the combine id pass through; combined packets are split into
// sub-messages, each delivered with first/last marks on the out_ channel.
// The cfg_ channel writes the combine protocol id (always ready); write it only
// while the block is idle.
// Path: each result is written into the queue, then into the output register.
// Throughput: one word per cycle while in_tready is high, set by the parser state update.
// Reset: parser idle, queue and output register empty, combine id 255.
// Stall: while out_tready is low, results collect in a queue of QUEUE_DEPTH
// entries plus the output register; in_tready drops when the queue is full.
module combined_frame_splitter #(
  parameter int LENGTH_BITS = cfs_pkg::LENGTH_BITS_DEF,
  parameter int QUEUE_DEPTH = cfs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // in_byte[7:0], packet_length[23:8], packet_protocol[31:24]
  input  logic        in_tuser,   // in_first
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // out_byte[7:0], out_protocol[15:8]
  output logic        out_tlast,  // out_last
  output logic [1:0]  out_tuser,  // out_first[0], out_empty[1]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  cfs_pkg::cfs_push_t push;
  cfs_pkg::cfs_item_t head;
  logic               full;
  logic               head_valid;
  logic               pop;
  logic               accept;

  assign in_tready = !full;
  assign cfg_ready = 1'b1;
  assign accept    = in_tvalid && in_tready;

  cfs_front #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_byte  (in_tdata[7:0]),
    .in_first (in_tuser),
    .pkt_len  (in_tdata[23:8]),
    .pkt_prot (in_tdata[31:24]),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .push     (push)
  );

  cfs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  cfs_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== dv/tb.sv =====
// Self-checking bench for combined_frame_splitter: random and directed packet words
// against a built-in deframing predictor, with random stalls on both streams.
// Depends on cfs_pkg and the combined_frame_splitter RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEN_BITS = cfs_pkg::LENGTH_BITS_DEF;
  localparam longint unsigned LEN_CAP = (64'd1 << LEN_BITS) - 1;
  localparam int CYCLE_LIMIT = 500000;

  typedef enum logic [2:0] {
    PM_IDLE, PM_PASS, PM_HDR_LO, PM_HDR_HI, PM_PAY_FIRST, PM_PAY, PM_DISCARD
  } parse_mode_t;

  typedef struct packed {
    logic        first;
    logic [31:0] data;
  } rx_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // in_byte[7:0], packet_length[23:8], packet_protocol[31:24]
  logic        in_tuser = 1'b0; // in_first
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // out_byte[7:0], out_protocol[15:8]
  logic        out_tlast;       // out_last
  logic [1:0]  out_tuser;       // out_first[0], out_empty[1]
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;

  rx_word_t           rx_feed_q[$];
  cfs_pkg::cfs_item_t deliver_q[$];
  int unsigned in_gap_max = 2;
  int unsigned out_stall_max = 2;
  int unsigned in_gap = 0;
  int unsigned out_stall = 0;
  int unsigned cycle_cnt = 0;
  int          err_cnt = 0;
  logic [7:0]  gen_combine = cfs_pkg::COMBINE_ID_RST;

  // predictor state
  logic [7:0]  combine_id = cfs_pkg::COMBINE_ID_RST;
  parse_mode_t pmode = PM_IDLE;
  logic [31:0] pkt_left = '0;
  logic [7:0]  hdr_lo = '0;
  logic [11:0] sub_left = '0;
  logic [7:0]  cur_prot = '0;

  combined_frame_splitter u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic push_delivery(input logic [7:0] b, input logic [7:0] pr, input logic f,
                               input logic l, input logic e);
    cfs_pkg::cfs_item_t it;
    it = '{data: b, protocol: pr, first: f, last: l, empty: e};
    deliver_q = {deliver_q, it};
  endtask

  task automatic deframe_word(input logic [31:0] w, input logic first);
    logic [7:0]  b;
    logic [7:0]  pr;
    logic [31:0] len;
    logic [15:0] head;
    logic [11:0] sz;
    b = w[7:0];
    len = {16'b0, w[23:8]};
    pr = w[31:24];
    if (first) begin
      if (len > LEN_CAP) len = 32'(LEN_CAP);
      sub_left = '0;
      hdr_lo = '0;
      if (len == 0) begin
        pmode = PM_IDLE;
        pkt_left = '0;
        return;
      end
      pkt_left = len;
      cur_prot = pr;
      if (pr != combine_id) begin
        push_delivery(b, pr, 1'b1, len == 1, 1'b0);
        pkt_left = len - 32'd1;
        pmode = (pkt_left == 0) ? PM_IDLE : PM_PASS;
        return;
      end
      pmode = PM_HDR_LO;
    end
    case (pmode)
      PM_PASS: push_delivery(b, cur_prot, 1'b0, pkt_left == 1, 1'b0);
      PM_HDR_LO: begin
        if (pkt_left < 2) begin
          pmode = PM_DISCARD;
        end else begin
          hdr_lo = b;
          pmode = PM_HDR_HI;
        end
      end
      PM_HDR_HI: begin
        head = {b, hdr_lo};
        sz = head[15:4];
        cur_prot = {4'b0, head[3:0]};
        if ((pkt_left - 32'd1) < {20'b0, sz}) begin
          pmode = PM_DISCARD;
        end else if (sz == 0) begin
          push_delivery(8'h00, cur_prot, 1'b1, 1'b1, 1'b1);
          pmode = PM_HDR_LO;
        end else begin
          sub_left = sz;
          pmode = PM_PAY_FIRST;
        end
      end
      PM_PAY_FIRST, PM_PAY: begin
        push_delivery(b, cur_prot, pmode == PM_PAY_FIRST, sub_left == 1, 1'b0);
        sub_left = sub_left - 12'd1;
        pmode = (sub_left == 0) ? PM_HDR_LO : PM_PAY;
      end
      PM_DISCARD: ;
      default: begin
        pmode = PM_IDLE;
        return;
      end
    endcase
    if (pkt_left != 0) pkt_left = pkt_left - 32'd1;
    if (pkt_left == 0) begin
      pmode = PM_IDLE;
      sub_left = '0;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) combine_id = cfg_data;
      if (in_tvalid && in_tready) deframe_word(in_tdata, in_tuser);
    end
  end

  // input driver
  always @(posedge clk) begin
    rx_word_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tuser <= 1'b0;
      in_gap <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (in_gap != 0) begin
        in_tvalid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (rx_feed_q.size() != 0) begin
        nxt = rx_feed_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= nxt.data;
        in_tuser <= nxt.first;
        in_gap <= $urandom_range(0, in_gap_max);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    cfs_pkg::cfs_item_t got;
    cfs_pkg::cfs_item_t want;
    int unsigned        stall;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_stall <= 0;
    end else if (out_tvalid && out_tready) begin
      got = '{data: out_tdata[7:0], protocol: out_tdata[15:8], first: out_tuser[0],
              last: out_tlast, empty: out_tuser[1]};
      if (deliver_q.size() == 0) begin
        $display("%0t: unexpected word byte=%h prot=%h first=%b last=%b empty=%b", $time,
                 got.data, got.protocol, got.first, got.last, got.empty);
        err_cnt++;
      end else begin
        want = deliver_q.pop_front();
        if (got.data !== want.data || got.protocol !== want.protocol ||
            got.first !== want.first || got.last !== want.last || got.empty !== want.empty) begin
          $display("%0t: mismatch exp byte=%h prot=%h first=%b last=%b empty=%b", $time,
                   want.data, want.protocol, want.first, want.last, want.empty);
          $display("%0t:          got byte=%h prot=%h first=%b last=%b empty=%b", $time,
                   got.data, got.protocol, got.first, got.last, got.empty);
          err_cnt++;
        end
      end
      stall = $urandom_range(0, out_stall_max);
      out_stall <= stall;
      out_tready <= (stall == 0);
    end else if (out_stall != 0) begin
      out_stall <= out_stall - 1;
      out_tready <= (out_stall == 1);
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic push_word(input logic [7:0] b, input logic first, input logic [15:0] len,
                           input logic [7:0] pr);
    rx_word_t wd;
    wd = '{first: first, data: {pr, len, b}};
    rx_feed_q = {rx_feed_q, wd};
  endtask

  task automatic send_packet(input logic [7:0] pr, input logic [15:0] plen,
                             input logic [7:0] body[$]);
    push_word(body[0], 1'b1, plen, pr);
    for (int i = 1; i < body.size(); i++)
      push_word(body[i], 1'b0, 16'($urandom), 8'($urandom));
  endtask

  task automatic run_directed();
    logic [7:0] d[$];
    push_word(8'h5A, 1'b0, 16'hFFFF, 8'hFF);   // stray word while idle
    push_word(8'hA5, 1'b1, 16'h0000, 8'h00);   // zero length
    d = '{8'hFF};
    send_packet(8'h00, 16'd1, d);
    d = '{8'h00, 8'hFF};                       // cut short by the next packet
    send_packet(8'h12, 16'd3, d);
    d = '{8'h2F, 8'h00, 8'hAA, 8'h55, 8'h00, 8'h00, 8'h7E};
    send_packet(8'hFF, 16'd7, d);              // sub of 2, empty sub, short header
    d = '{8'hF3, 8'hFF, 8'h01, 8'h02, 8'h03};
    send_packet(8'hFF, 16'd5, d);              // size 4095 overruns packet
    d = '{8'h80};
    send_packet(8'hFF, 16'd1, d);
    d = '{8'h01, 8'h02, 8'h03};
    send_packet(8'hFE, 16'hFFFF, d);           // max length, abandoned
    d = '{8'h15, 8'h00, 8'h80, 8'h42};
    send_packet(8'hFF, 16'd4, d);
  endtask

  task automatic gen_traffic(input int n);
    logic [7:0]  body[$];
    logic [15:0] hdr;
    logic [7:0]  pr;
    int unsigned plen;
    int          sent;
    int          kind;
    int          fate;
    int          sz;
    int          cut;
    sent = 0;
    while (sent < n) begin
      body.delete();
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        repeat ($urandom_range(1, 4)) begin
          sz = ($urandom_range(0, 29) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 12);
          hdr = {12'(sz), 4'($urandom)};
          body = {body, hdr[7:0]};
          body = {body, hdr[15:8]};
          repeat (sz) body = {body, 8'($urandom)};
        end
        pr = gen_combine;
      end else if (kind < 85) begin
        repeat ($urandom_range(1, 20)) body = {body, 8'($urandom)};
        do pr = 8'($urandom); while (pr == gen_combine);
      end else if (kind < 90) begin
        repeat ($urandom_range(1, 3))
          push_word(8'($urandom), 1'b0, 16'($urandom), 8'($urandom));
        continue;
      end else if (kind < 93) begin
        push_word(8'($urandom), 1'b1, 16'h0000, 8'($urandom));
        continue;
      end else begin
        repeat ($urandom_range(1, 16)) body = {body, 8'($urandom)};
        pr = gen_combine;
      end
      plen = body.size();
      fate = $urandom_range(0, 99);
      if (fate >= 70 && fate < 85 && body.size() > 1) begin
        cut = $urandom_range(1, body.size() - 1);
        body = body[0:cut-1];
        plen = cut;
      end else if (fate >= 85 && fate < 93) begin
        body = {body, 8'($urandom)};           // trails past the declared length
      end else if (fate >= 93) begin
        plen = body.size() + $urandom_range(1, 65535 - body.size());
      end
      sent += body.size();
      send_packet(pr, 16'(plen), body);
    end
    push_word(8'($urandom), 1'b1, 16'h0000, 8'($urandom));  // park parser in idle
  endtask

  task automatic wait_idle();
    while (rx_feed_q.size() != 0 || in_tvalid || deliver_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_combine_id(input logic [7:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    gen_combine = v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [7:0]  cfg_set[5];
    int unsigned gap_set[5];
    int unsigned stall_set[5];
    cfg_set = '{8'h00, 8'hFF, 8'h00, 8'h5A, 8'hFF};
    cfg_set[2] = 8'($urandom_range(1, 254));
    gap_set = '{0, 19, 0, 3, 19};
    stall_set = '{0, 0, 19, 3, 19};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    run_directed();
    for (int i = 0; i < 5; i++) begin
      wait_idle();
      write_combine_id(cfg_set[i]);
      in_gap_max = gap_set[i];
      out_stall_max = stall_set[i];
      @(negedge clk);
      gen_traffic(240);
    end
    wait_idle();
    if (err_cnt == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/cfs_pkg.sv
rtl/cfs_front.sv
rtl/cfs_queue.sv
rtl/cfs_out_stage.sv
rtl/combined_frame_splitter.sv
dv/tb.sv
